// ===== rtl/lspl_pkg.sv =====
// Package for the line start position locator.
// Holds sizes, command and operation codes, and the payload types.
// No dependencies; every other file of the block imports it.
package lspl_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned START_WIDTH = 32;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned INDEX_W  = 13;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned LINE_W   = 13;
  localparam int unsigned COLUMN_W = 33;
  localparam int unsigned OFFSET_W = 32;

  // Configuration port
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_LINE_COUNT = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_LOCATE = 2'd1,
    CMD_RANGE  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_LOCATE = 2'd1,
    OP_RANGE  = 2'd2,
    OP_REJECT = 2'd3
  } op_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                ok;
    logic [LINE_W-1:0]   line;
    logic [COLUMN_W-1:0] column;
    logic [OFFSET_W-1:0] first_offset;
    logic [OFFSET_W-1:0] last_offset;
  } out_item_t;

  // Classified operation handed from the front to the back
  typedef struct packed {
    op_e                op;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } q_entry_t;

  typedef struct packed {
    logic busy;
    logic out_valid;
  } back_status_t;

endpackage

// ===== rtl/lspl_if.sv =====
// Valid/ready channel interfaces for the line start position locator.
// Depends on lspl_pkg for the payload types.
interface lspl_in_if;
  import lspl_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lspl_out_if;
  import lspl_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lspl_front.sv =====
// Front end: accepts input transactions and classifies them into operations.
// Depends on lspl_pkg.
module lspl_front (
  input  logic                    in_valid_i,
  input  lspl_pkg::in_item_t      in_data_i,
  output logic                    in_ready_o,
  input  logic [lspl_pkg::CNT_W-1:0] count_i,
  output logic                    q_valid_o,
  output lspl_pkg::q_entry_t      q_entry_o,
  input  logic                    q_ready_i
);
  import lspl_pkg::*;

  logic [31:0] idx_w;
  logic [31:0] cnt_w;

  assign idx_w = 32'(in_data_i.index);
  assign cnt_w = 32'(count_i);

  // Classify: reject what can be decided without the table
  always_comb begin
    q_entry_o.index = in_data_i.index;
    q_entry_o.value = in_data_i.value;
    q_entry_o.op    = OP_REJECT;
    unique case (in_data_i.command)
      CMD_WRITE: begin
        if (idx_w < 32'(TABLE_DEPTH)) q_entry_o.op = OP_WRITE;
      end
      CMD_LOCATE: begin
        if (cnt_w != 32'd0) q_entry_o.op = OP_LOCATE;
      end
      CMD_RANGE: begin
        if (idx_w >= 32'd1 && idx_w <= cnt_w) q_entry_o.op = OP_RANGE;
      end
      default: q_entry_o.op = OP_REJECT;
    endcase
  end

  assign q_valid_o  = in_valid_i;
  assign in_ready_o = q_ready_i;

endmodule

// ===== rtl/lspl_queue.sv =====
// Two-entry queue between the front and the back of the locator.
// Depends on lspl_pkg for the entry type.
module lspl_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  input  lspl_pkg::q_entry_t push_entry_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output lspl_pkg::q_entry_t pop_entry_o,
  input  logic               pop_ready_i
);
  import lspl_pkg::*;

  q_entry_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_entry_o  = entry_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

// ===== rtl/lspl_back.sv =====
// Back end: owns the line start table and runs writes, range reads and the
// binary search, one operation at a time, into a result register.
// Depends on lspl_pkg.
module lspl_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [lspl_pkg::CNT_W-1:0] count_i,
  input  logic                       q_valid_i,
  input  lspl_pkg::q_entry_t         q_entry_i,
  output logic                       q_ready_o,
  output logic                       out_valid_o,
  output lspl_pkg::out_item_t        out_data_o,
  input  logic                       out_ready_i,
  output lspl_pkg::back_status_t     status_o
);
  import lspl_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_BOUND  = 6'b000010,
    ST_PROBE  = 6'b000100,
    ST_COLUMN = 6'b001000,
    ST_RFIRST = 6'b010000,
    ST_RNEXT  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [START_WIDTH-1:0] start_mem [TABLE_DEPTH];
  logic [START_WIDTH-1:0] rd_data_q;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_addr;

  logic [VALUE_W-1:0]   val_q, val_d;
  logic [INDEX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [OFFSET_W-1:0]  first_q, first_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_data_q, res_data;
  logic                 res_set;
  logic                 out_free, pop;
  logic [31:0]          rd_ext;
  logic [CNT_W-1:0]     span;

  assign out_free  = !out_valid_q || out_ready_i;
  assign q_ready_o = (state_q == ST_IDLE) && out_free;
  assign pop       = q_valid_i && q_ready_o;
  assign rd_ext    = 32'(rd_data_q);

  // Sequence one operation through the table
  always_comb begin
    state_d  = state_q;
    val_d    = val_q;
    idx_d    = idx_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    first_d  = first_q;
    span     = '0;
    mem_we   = 1'b0;
    mem_addr = mid_q[ADDR_W-1:0];
    res_set  = 1'b0;
    res_data = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          val_d = q_entry_i.value;
          idx_d = q_entry_i.index;
          unique case (q_entry_i.op)
            OP_WRITE: begin
              mem_we      = 1'b1;
              mem_addr    = q_entry_i.index[ADDR_W-1:0];
              res_set     = 1'b1;
              res_data.ok = 1'b1;
            end
            OP_LOCATE: begin
              mem_addr = ADDR_W'(count_i - CNT_W'(1));
              state_d  = ST_BOUND;
            end
            OP_RANGE: begin
              mem_addr = ADDR_W'(q_entry_i.index - INDEX_W'(1));
              state_d  = ST_RFIRST;
            end
            default: res_set = 1'b1;
          endcase
        end
      end
      ST_BOUND: begin
        // Reject a position past the last start, else open the search
        lo_d = '0;
        hi_d = count_i;
        if (val_q > rd_ext) begin
          res_set = 1'b1;
          state_d = ST_IDLE;
        end else if (count_i > CNT_W'(1)) begin
          mid_d    = count_i >> 1;
          mem_addr = mid_d[ADDR_W-1:0];
          state_d  = ST_PROBE;
        end else begin
          mem_addr = '0;
          state_d  = ST_COLUMN;
        end
      end
      ST_PROBE: begin
        // Halve the window around the probed start
        if (rd_ext > val_q) hi_d = mid_q;
        else lo_d = mid_q;
        span = hi_d - lo_d;
        if (span > CNT_W'(1)) begin
          mid_d    = lo_d + (span >> 1);
          mem_addr = mid_d[ADDR_W-1:0];
        end else begin
          mem_addr = lo_d[ADDR_W-1:0];
          state_d  = ST_COLUMN;
        end
      end
      ST_COLUMN: begin
        res_set         = 1'b1;
        res_data.ok     = 1'b1;
        res_data.line   = LINE_W'(32'(lo_q) + 32'd1);
        res_data.column = COLUMN_W'({1'b0, val_q}) - COLUMN_W'(rd_ext) + COLUMN_W'(1);
        state_d         = ST_IDLE;
      end
      ST_RFIRST: begin
        first_d = rd_ext;
        if (32'(idx_q) == 32'(count_i)) begin
          res_set               = 1'b1;
          res_data.ok           = 1'b1;
          res_data.first_offset = rd_ext;
          res_data.last_offset  = rd_ext;
          state_d               = ST_IDLE;
        end else begin
          mem_addr = idx_q[ADDR_W-1:0];
          state_d  = ST_RNEXT;
        end
      end
      ST_RNEXT: begin
        res_set               = 1'b1;
        res_data.ok           = 1'b1;
        res_data.first_offset = first_q;
        res_data.last_offset  = rd_ext - 32'd1;
        state_d               = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result until it is taken
  always_comb begin
    if (res_set) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    idx_q   <= idx_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    first_q <= first_d;
    if (res_set) out_data_q <= res_data;
  end

  // Line start table, one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) start_mem[mem_addr] <= q_entry_i.value[START_WIDTH-1:0];
    rd_data_q <= start_mem[mem_addr];
  end

  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_data_q;
  assign status_o.busy      = (state_q != ST_IDLE);
  assign status_o.out_valid = out_valid_q;

endmodule

// ===== rtl/line_start_position_locator_unit.sv =====
// Line start position locator, top level.
// After leaving the queue, a write or a front-rejected item sets the result directly;
// a range takes two table reads (one for the last line); a locate reads the last
// start, then one dependent table read per search step, or stops there if past it.
// The back end takes one item at a time; the queue keeps accepting meanwhile until full.
// Reset clears the line count, the queue and the sequencer; the table is not cleared.
module line_start_position_locator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lspl_in_if.sink                           item_i,
  lspl_out_if.source                        result_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lspl_pkg::PADDR_W-1:0]      paddr,
  input  logic [lspl_pkg::PDATA_W-1:0]      pwdata,
  output logic [lspl_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import lspl_pkg::*;

  logic [CFG_W-1:0]   num_lines_q, num_lines_d;
  logic [CNT_W-1:0]   count;
  logic               cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;
  logic               f_valid, f_ready;
  q_entry_t           f_entry;
  logic               b_valid, b_ready;
  q_entry_t           b_entry;
  back_status_t       status;

  // Configuration register
  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready && (reg_idx == REG_LINE_COUNT);
  assign num_lines_d = cfg_write ? pwdata[CFG_W-1:0] : num_lines_q;
  assign prdata = (reg_idx == REG_LINE_COUNT) ? PDATA_W'(num_lines_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) num_lines_q <= '0;
    else num_lines_q <= num_lines_d;
  end

  // Clamp the live line count to the table depth
  assign count = (32'(num_lines_q) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                       : CNT_W'(num_lines_q);

  lspl_front u_front (
    .in_valid_i (item_i.valid),
    .in_data_i  (item_i.data),
    .in_ready_o (item_i.ready),
    .count_i    (count),
    .q_valid_o  (f_valid),
    .q_entry_o  (f_entry),
    .q_ready_i  (f_ready)
  );

  lspl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_entry_i (f_entry),
    .push_ready_o (f_ready),
    .pop_valid_o  (b_valid),
    .pop_entry_o  (b_entry),
    .pop_ready_i  (b_ready)
  );

  lspl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .count_i     (count),
    .q_valid_i   (b_valid),
    .q_entry_i   (b_entry),
    .q_ready_o   (b_ready),
    .out_valid_o (result_o.valid),
    .out_data_o  (result_o.data),
    .out_ready_i (result_o.ready),
    .status_o    (status)
  );

`ifndef ASSERT_OFF
  // The result register stays empty while an operation is in flight
  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> !result_o.valid)
    else $error("result pending while back end busy");

  // A dequeued operation either runs or leaves a result
  a_pop_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid && b_ready) |=> (status.busy || result_o.valid))
    else $error("dequeued operation lost");

  // A rejected result carries zeros only
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.data.ok) |->
      (result_o.data.line == '0 && result_o.data.column == '0 &&
       result_o.data.first_offset == '0 && result_o.data.last_offset == '0))
    else $error("rejected result has nonzero fields");

  // A located line lies within the line count
  a_line_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && status.out_valid) |-> (32'(result_o.data.line) <= 32'(count)))
    else $error("line beyond line count");
`endif

endmodule
